// File: hdl/rmt_pkg.sv
// Package for the recursive mutex table: request and response types,
// status, action, lock word and lock type codes, and parameter defaults.
// No dependencies.
package rmt_pkg;

   localparam int NUM_LOCKS_DEF  = 8;
   localparam int DEPTH_BITS_DEF = 32;

   typedef enum logic [1:0] {
      ACT_LOCK    = 2'd0,
      ACT_TRYLOCK = 2'd1,
      ACT_UNLOCK  = 2'd2,
      ACT_INVALID = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BUSY      = 3'd1,
      ST_DEADLOCK  = 3'd2,
      ST_OVERFLOW  = 3'd3,
      ST_NOT_OWNER = 3'd4,
      ST_MUST_WAIT = 3'd5
   } status_type;

   localparam logic [1:0] WORD_FREE      = 2'd0;
   localparam logic [1:0] WORD_HELD      = 2'd1;
   localparam logic [1:0] WORD_CONTENDED = 2'd2;

   localparam logic [1:0] TYPE_NORMAL    = 2'd0;
   localparam logic [1:0] TYPE_RECURSIVE = 2'd1;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1
   } state_type;

   typedef struct packed {
      logic [1:0] action;
      logic [2:0] lock_index;
      logic [7:0] requester;
   } req_type;

   typedef struct packed {
      status_type status;
      logic       wake_one;
   } rsp_type;

endpackage

// File: hdl/recursive_mutex_table.sv
// Recursive mutex table: one request in, one response out per request.
// The request and its lock entry are registered on acceptance; the response is
// registered when the execute state completes, held back while a pending response
// is stalled. No new request is taken until then: the entry read precedes its write-back.
// Reset is synchronous and active high; it clears the control state, the lock
// type map and the per-entry valid bits, so every lock reads as free at once.
module recursive_mutex_table
   import rmt_pkg::*;
#(
   parameter int NUM_LOCKS  = NUM_LOCKS_DEF,
   parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int AW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
   localparam int EW = 10 + DEPTH_BITS;

   logic [EW-1:0]        mem [NUM_LOCKS];
   logic [NUM_LOCKS-1:0] valid_ff;

   state_type            state_ff, state_in;
   req_type              req_ff;
   logic [15:0]          type_map_ff;
   logic [EW-1:0]        rd_data_ff;
   logic                 rd_hit_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff, rsp_in;

   logic                 req_accept;
   logic                 exec_fire;
   logic                 mem_we;
   logic [EW-1:0]        wr_data;
   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        wr_addr;

   assign req_accept = req_valid && !req_stall;
   assign rd_addr    = AW'(req_data.lock_index);
   assign wr_addr    = AW'(req_ff.lock_index);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_fire) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = (state_ff != S_IDLE);
      exec_fire = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         type_map_ff <= '0;
      end else if (csr_wr_en) begin
         type_map_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff <= mem[rd_addr];
         rd_hit_ff  <= valid_ff[rd_addr];
      end
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_comb begin
      logic [1:0]            word;
      logic [7:0]            owner;
      logic [DEPTH_BITS-1:0] depth;
      logic [1:0]            ltype;
      logic                  in_range;
      logic                  is_owner;
      logic                  is_try;
      logic                  write;
      logic [1:0]            new_word;
      logic [7:0]            new_owner;
      logic [DEPTH_BITS-1:0] new_depth;

      if (rd_hit_ff) begin
         word  = rd_data_ff[EW-1 -: 2];
         owner = rd_data_ff[EW-3 -: 8];
         depth = rd_data_ff[DEPTH_BITS-1:0];
      end else begin
         word  = WORD_FREE;
         owner = '0;
         depth = '0;
      end
      ltype     = type_map_ff[2*req_ff.lock_index +: 2];
      in_range  = 32'(req_ff.lock_index) < NUM_LOCKS;
      is_owner  = (owner == req_ff.requester);
      is_try    = (req_ff.action == ACT_TRYLOCK);
      write     = 1'b0;
      new_word  = word;
      new_owner = owner;
      new_depth = depth;
      rsp_in.status   = ST_OK;
      rsp_in.wake_one = 1'b0;

      priority if (req_ff.action == ACT_INVALID) begin
         rsp_in.status = ST_BUSY;
      end else if (req_ff.requester == 8'd0) begin
         rsp_in.status = ST_NOT_OWNER;
      end else if (!in_range) begin
         rsp_in.status = (req_ff.action == ACT_UNLOCK) ? ST_NOT_OWNER : ST_BUSY;
      end else if (req_ff.action == ACT_UNLOCK) begin
         priority if (!is_owner) begin
            rsp_in.status = ST_NOT_OWNER;
         end else if (depth > DEPTH_BITS'(1)) begin
            write     = 1'b1;
            new_depth = depth - DEPTH_BITS'(1);
         end else begin
            write           = 1'b1;
            rsp_in.wake_one = (word == WORD_CONTENDED);
            new_word        = WORD_FREE;
            new_owner       = '0;
            new_depth       = '0;
         end
      end else begin
         priority if (word == WORD_FREE) begin
            write     = 1'b1;
            new_word  = WORD_HELD;
            new_owner = req_ff.requester;
            new_depth = DEPTH_BITS'(1);
         end else if (is_owner && ltype == TYPE_RECURSIVE) begin
            if (depth == '1) begin
               rsp_in.status = ST_OVERFLOW;
            end else begin
               write     = 1'b1;
               new_depth = depth + DEPTH_BITS'(1);
            end
         end else if (is_try) begin
            rsp_in.status = ST_BUSY;
         end else if (is_owner && ltype != TYPE_NORMAL) begin
            rsp_in.status = ST_DEADLOCK;
         end else begin
            write         = 1'b1;
            new_word      = WORD_CONTENDED;
            rsp_in.status = ST_MUST_WAIT;
         end
      end

      mem_we  = exec_fire && write;
      wr_data = {new_word, new_owner, new_depth};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == S_EXEC)
      else $error("Accepted request did not enter the execute state.");

   a_write_in_exec: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == S_EXEC && exec_fire)
      else $error("Lock memory written outside a completing execute cycle.");

   a_fire_to_rsp: assert property (@(posedge clock) disable iff (reset)
      exec_fire |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("Completed request did not produce a response.");

   a_wake_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !rsp_ff.wake_one || rsp_ff.status == ST_OK)
      else $error("Wake flag raised on a failed request.");

endmodule
